### hdl/geohash_point_encoder_defines.svh
// ---------------------------------------------------------------------------
// Geohash point encoder assertion macros
// Shared property wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef GEOHASH_POINT_ENCODER_DEFINES_SVH
`define GEOHASH_POINT_ENCODER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define GHPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must also hold across reset.
`define GHPE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ghpe_pkg.sv
// ---------------------------------------------------------------------------
// Geohash point encoder package
// Status codes, register indexes and field widths.
// ---------------------------------------------------------------------------
package ghpe_pkg;

  localparam int COORD_W = 64;
  localparam int STEP_W  = 6;
  localparam int CELL_W  = 52;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic [IDX_W-1:0] REG_LAT_MIN = 2'd0;
  localparam logic [IDX_W-1:0] REG_LAT_MAX = 2'd1;
  localparam logic [IDX_W-1:0] REG_LNG_MIN = 2'd2;
  localparam logic [IDX_W-1:0] REG_LNG_MAX = 2'd3;

endpackage

### hdl/ghpe_div_step.sv
// ---------------------------------------------------------------------------
// Geohash divider step
// One restoring division iteration: shift remainder, subtract span if it fits.
// ---------------------------------------------------------------------------
module ghpe_div_step #(
  parameter int QW = 26
) (
  input  logic [ghpe_pkg::COORD_W-1:0] rem_in,
  input  logic [QW-1:0]                quo_in,
  input  logic [ghpe_pkg::COORD_W-1:0] span,
  output logic [ghpe_pkg::COORD_W-1:0] rem_out,
  output logic [QW-1:0]                quo_out
);

  logic [ghpe_pkg::COORD_W:0] shifted;
  logic [ghpe_pkg::COORD_W:0] diff;
  logic                       take;
  logic [QW:0]                quo_ext;

  always_comb begin
    shifted = {rem_in, 1'b0};
    diff    = shifted - {1'b0, span};
    take    = shifted >= {1'b0, span};
    rem_out = take ? diff[ghpe_pkg::COORD_W-1:0] : shifted[ghpe_pkg::COORD_W-1:0];
    quo_ext = {quo_in, take};
    quo_out = quo_ext[QW-1:0];
  end

endmodule

### hdl/geohash_point_encoder.sv
// ---------------------------------------------------------------------------
// Geohash point encoder
// Maps a fixed-point latitude/longitude onto an interleaved integer geohash.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_axis    in         latitude, longitude, precision
//  m_axis    out        cell_bits, cell_step, status
//  cfg       in         register index and 64-bit bound value
//
// One item enters per cycle while the output is not stalled. An item passes
// an input register, a check/offset stage, one stage per quotient bit of
// the restoring divider (both axes side by side), and the output register,
// which the interleave logic feeds. Reset is synchronous and clears all
// valid bits and restores the bounds. A stalled output freezes the whole
// pipeline; nothing is lost or repeated. Bound changes reach the range check
// from the bound registers, and the divider through spans registered from them.
module geohash_point_encoder #(
  parameter int MAX_STEP  = 26,
  parameter int FRAC_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] latitude, [127:64] longitude, [133:128] precision, rest zero
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [51:0] cell_bits, [57:52] cell_step, [59:58] status, rest zero
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [ghpe_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ghpe_pkg::COORD_W-1:0] cfg_data
);

  localparam int CW = ghpe_pkg::COORD_W;
  localparam int SW = ghpe_pkg::STEP_W;
  localparam int HW = 2 * MAX_STEP;

  // Reset bounds: +/-85.05112878 and +/-180 degrees in fixed point.
  localparam logic [CW-1:0] LAT_LIM = (64'd85 << FRAC_BITS) +
    (((64'd5112878 << FRAC_BITS) + 64'd50000000) / 64'd100000000);
  localparam logic [CW-1:0] LNG_LIM = 64'd180 << FRAC_BITS;

  // Configuration registers.
  logic [CW-1:0] lat_min, lat_max, lng_min, lng_max;
  logic [CW-1:0] lat_span, lng_span;
  logic          range_bad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_min <= -LAT_LIM;
      lat_max <= LAT_LIM;
      lng_min <= -LNG_LIM;
      lng_max <= LNG_LIM;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ghpe_pkg::REG_LAT_MIN: lat_min <= cfg_data;
        ghpe_pkg::REG_LAT_MAX: lat_max <= cfg_data;
        ghpe_pkg::REG_LNG_MIN: lng_min <= cfg_data;
        ghpe_pkg::REG_LNG_MAX: lng_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Spans and the empty-range flag are registered from the bounds.
  always_ff @(posedge clk) begin
    lat_span  <= lat_max - lat_min;
    lng_span  <= lng_max - lng_min;
    range_bad <= ($signed(lat_max) <= $signed(lat_min)) ||
                 ($signed(lng_max) <= $signed(lng_min));
  end

  // The whole pipeline advances unless a finished result is held.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input register.
  logic          in_v;
  logic [CW-1:0] in_lat, in_lng;
  logic [SW-1:0] in_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (adv) begin
      in_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_lat  <= s_axis_tdata[63:0];
      in_lng  <= s_axis_tdata[127:64];
      in_step <= s_axis_tdata[133:128];
    end
  end

  // Pipeline through the divider: index k holds the state after k bits.
  logic                          pv      [0:MAX_STEP];
  logic [CW-1:0]                 lat_rem [0:MAX_STEP];
  logic [CW-1:0]                 lng_rem [0:MAX_STEP];
  logic [MAX_STEP-1:0]           lat_quo [0:MAX_STEP];
  logic [MAX_STEP-1:0]           lng_quo [0:MAX_STEP];
  logic [SW-1:0]                 pstep   [0:MAX_STEP];
  logic [ghpe_pkg::STAT_W-1:0]   pstat   [0:MAX_STEP];
  logic                          lat_top [0:MAX_STEP];
  logic                          lng_top [0:MAX_STEP];

  // Check and offset stage. A point on the max bound takes the last cell;
  // inside the box the offset is below the span so the divider is exact.
  logic [ghpe_pkg::STAT_W-1:0] stat_next;

  always_comb begin
    if (in_step == '0 || in_step > SW'(MAX_STEP) || range_bad) begin
      stat_next = ghpe_pkg::ST_BAD;
    end else if ($signed(in_lat) < $signed(lat_min) || $signed(in_lat) > $signed(lat_max) ||
                 $signed(in_lng) < $signed(lng_min) || $signed(in_lng) > $signed(lng_max)) begin
      stat_next = ghpe_pkg::ST_RANGE;
    end else begin
      stat_next = ghpe_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (adv) begin
      pv[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_rem[0] <= in_lat - lat_min;
      lng_rem[0] <= in_lng - lng_min;
      lat_quo[0] <= '0;
      lng_quo[0] <= '0;
      pstep[0]   <= in_step;
      pstat[0]   <= stat_next;
      lat_top[0] <= in_lat == lat_max;
      lng_top[0] <= in_lng == lng_max;
    end
  end

  for (genvar k = 1; k <= MAX_STEP; k++) begin : g_div
    logic [CW-1:0]       lat_rem_next, lng_rem_next;
    logic [MAX_STEP-1:0] lat_quo_next, lng_quo_next;

    ghpe_div_step #(.QW(MAX_STEP)) u_lat (
      .rem_in (lat_rem[k-1]),
      .quo_in (lat_quo[k-1]),
      .span   (lat_span),
      .rem_out(lat_rem_next),
      .quo_out(lat_quo_next)
    );

    ghpe_div_step #(.QW(MAX_STEP)) u_lng (
      .rem_in (lng_rem[k-1]),
      .quo_in (lng_quo[k-1]),
      .span   (lng_span),
      .rem_out(lng_rem_next),
      .quo_out(lng_quo_next)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k] <= 1'b0;
      end else if (adv) begin
        pv[k] <= pv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lat_rem[k] <= lat_rem_next;
        lng_rem[k] <= lng_rem_next;
        lat_quo[k] <= lat_quo_next;
        lng_quo[k] <= lng_quo_next;
        pstep[k]   <= pstep[k-1];
        pstat[k]   <= pstat[k-1];
        lat_top[k] <= lat_top[k-1];
        lng_top[k] <= lng_top[k-1];
      end
    end
  end

  // Interleave stage. The divider always produces MAX_STEP bits, so the
  // cell for a shorter step is the quotient shifted down.
  logic [SW-1:0]       drop;
  logic [MAX_STEP-1:0] lat_cell, lng_cell, ones;
  logic [HW-1:0]       hash;
  logic [HW+ghpe_pkg::CELL_W-1:0] hash_ext;
  logic [ghpe_pkg::CELL_W-1:0]    cell_bits;

  always_comb begin
    drop     = SW'(MAX_STEP) - pstep[MAX_STEP];
    ones     = {MAX_STEP{1'b1}} >> drop;
    lat_cell = lat_top[MAX_STEP] ? ones : (lat_quo[MAX_STEP] >> drop);
    lng_cell = lng_top[MAX_STEP] ? ones : (lng_quo[MAX_STEP] >> drop);
    for (int i = 0; i < MAX_STEP; i++) begin
      hash[2*i]   = lng_cell[i];
      hash[2*i+1] = lat_cell[i];
    end
    hash_ext  = {{ghpe_pkg::CELL_W{1'b0}}, hash};
    cell_bits = (pstat[MAX_STEP] == ghpe_pkg::ST_OK) ?
                hash_ext[ghpe_pkg::CELL_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= pv[MAX_STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {4'b0, pstat[MAX_STEP], pstep[MAX_STEP], cell_bits};
    end
  end

endmodule

### hdl/ghpe_checker.sv
// ---------------------------------------------------------------------------
// Geohash point encoder checker
// Port-level properties of the encoder, attached by bind.
// ---------------------------------------------------------------------------
`include "geohash_point_encoder_defines.svh"

module ghpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A held result stays put until taken.
  `GHPE_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  // Every error status comes with an all-zero hash.
  `GHPE_ASSERT(a_err_zero, m_axis_tvalid && m_axis_tdata[59:58] != ghpe_pkg::ST_OK |-> m_axis_tdata[51:0] == '0, "error item carries hash bits")
  // A zero step is always reported as a bad parameter.
  `GHPE_ASSERT(a_step0, m_axis_tvalid && m_axis_tdata[57:52] == '0 |-> m_axis_tdata[59:58] == ghpe_pkg::ST_BAD, "zero step not flagged")
  // No item appears right after reset.
  `GHPE_ASSERT_RST(a_rst, rst |=> !m_axis_tvalid, "valid result after reset")

endmodule

bind geohash_point_encoder ghpe_checker u_ghpe_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### tb/geohash_point_encoder_test.sv
// ---------------------------------------------------------------------------
// Geohash point encoder testbench
// Streams latitude/longitude/precision items through the encoder under
// several bounding boxes and compares each hash result with a predictor
// that runs alongside, under random idling on both sides and back-pressure.
// ---------------------------------------------------------------------------
module geohash_point_encoder_test;

  localparam int MAX_STEP   = 26;
  localparam int LATENCY    = MAX_STEP + 3;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [ghpe_pkg::CELL_W-1:0] bits;
    logic [ghpe_pkg::STEP_W-1:0] step;
    logic [ghpe_pkg::STAT_W-1:0] status;
  } cell_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [63:0] latitude, [127:64] longitude, [133:128] precision, rest zero
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [51:0] cell_bits, [57:52] cell_step, [59:58] status, rest zero
  logic [63:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [ghpe_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [ghpe_pkg::COORD_W-1:0] cfg_data = '0;

  // Our own copy of the four bounds.
  logic [63:0] box_lat_min, box_lat_max, box_lng_min, box_lng_max;

  cell_result_t pending_hashes[$];
  int errors = 0;
  bit tx_quiet = 0;      // sender never idles while set
  bit rx_quiet = 0;      // receiver never idles while set
  int hold_request = 0;  // bumped by a test to ask for one long receiver stall
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  geohash_point_encoder #(.MAX_STEP(MAX_STEP), .FRAC_BITS(32)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Signed less-than on raw 64-bit patterns.
  function automatic bit coord_below(logic [63:0] a, logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // floor(off * 2^step / span) by restoring division; an offset that reaches
  // the span (point on the max bound) lands in the last cell.
  function automatic logic [63:0] grid_cell(logic [63:0] off, logic [63:0] span,
                                            int step);
    logic [63:0] quot;
    logic [63:0] rem;
    logic        carry;
    quot = '0;
    rem  = off;
    if (off >= span) return (64'd1 << step) - 64'd1;
    for (int i = 0; i < step; i++) begin
      carry = rem[63];
      rem   = rem << 1;
      quot  = quot << 1;
      if (carry || rem >= span) begin
        rem     = rem - span;
        quot[0] = 1'b1;
      end
    end
    return quot;
  endfunction

  function automatic cell_result_t hash_point(logic [63:0] lat, logic [63:0] lng,
                                              logic [5:0] step);
    cell_result_t res;
    logic [63:0] lat_cell, lng_cell, woven;
    woven      = '0;
    res.step   = step;
    res.status = ghpe_pkg::ST_OK;
    if (step == 0 || step > MAX_STEP ||
        !coord_below(box_lat_min, box_lat_max) ||
        !coord_below(box_lng_min, box_lng_max)) begin
      res.status = ghpe_pkg::ST_BAD;
    end else if (coord_below(lat, box_lat_min) || coord_below(box_lat_max, lat) ||
                 coord_below(lng, box_lng_min) || coord_below(box_lng_max, lng)) begin
      res.status = ghpe_pkg::ST_RANGE;
    end else begin
      lat_cell = grid_cell(lat - box_lat_min, box_lat_max - box_lat_min, step);
      lng_cell = grid_cell(lng - box_lng_min, box_lng_max - box_lng_min, step);
      // Longitude on even bits, latitude on odd bits.
      for (int i = 0; i < 32; i++) begin
        woven[2*i]   = lng_cell[i];
        woven[2*i+1] = lat_cell[i];
      end
    end
    res.bits = woven[ghpe_pkg::CELL_W-1:0];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A coordinate mostly inside [lo, hi], sometimes on a bound, sometimes anywhere.
  function automatic logic [63:0] pick_coord(logic [63:0] lo, logic [63:0] hi);
    logic [63:0] span;
    int roll;
    span = hi - lo;
    roll = $urandom_range(99);
    if (!coord_below(lo, hi) || roll < 12) return rand64();
    if (roll < 17) return lo;
    if (roll < 22) return hi;
    if (roll < 26) return hi + 64'd1 + ($urandom_range(3));
    if (roll < 30) return lo - 64'd1 - ($urandom_range(3));
    if (span == '1) return rand64();
    return lo + (rand64() % (span + 64'd1));
  endfunction

  function automatic logic [5:0] pick_step();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 6'($urandom_range(63));
    if (roll < 20) return 6'(MAX_STEP - $urandom_range(2));
    return 6'($urandom_range(MAX_STEP, 1));
  endfunction

  // ---------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------

  // Offers one point and holds it until the encoder takes it; the expected
  // hash is queued at acceptance using the bounds in force.
  task automatic send_point(logic [63:0] lat, logic [63:0] lng, logic [5:0] step);
    s_axis_tdata  <= {2'b00, step, lng, lat};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_hashes.push_back(hash_point(lat, lng, step));
    if (!tx_quiet && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hashes.size() != 0) @(posedge clk);
  endtask

  // Bounds are only rewritten while nothing is in flight.
  task automatic write_bound(logic [ghpe_pkg::IDX_W-1:0] idx, logic [63:0] value);
    wait_drained();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      ghpe_pkg::REG_LAT_MIN: box_lat_min = value;
      ghpe_pkg::REG_LAT_MAX: box_lat_max = value;
      ghpe_pkg::REG_LNG_MIN: box_lng_min = value;
      default:               box_lng_max = value;
    endcase
  endtask

  task automatic set_box(logic [63:0] la0, logic [63:0] la1,
                         logic [63:0] ln0, logic [63:0] ln1);
    write_bound(ghpe_pkg::REG_LAT_MIN, la0);
    write_bound(ghpe_pkg::REG_LAT_MAX, la1);
    write_bound(ghpe_pkg::REG_LNG_MIN, ln0);
    write_bound(ghpe_pkg::REG_LNG_MAX, ln1);
  endtask

  task automatic send_random_points(int count);
    for (int i = 0; i < count; i++)
      send_point(pick_coord(box_lat_min, box_lat_max),
                 pick_coord(box_lng_min, box_lng_max), pick_step());
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("t=%0t mismatch on %s: got 0x%0h expected 0x%0h", $time, field, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset box: bad steps, corners, the max-bound clamp and points just outside.
  task automatic test_reset_box();
    send_point(64'd0, 64'd0, 6'd0);
    send_point(64'd0, 64'd0, 6'(MAX_STEP + 1));
    send_point(64'd0, 64'd0, 6'd63);
    send_point(64'd0, 64'd0, 6'd1);
    send_point(64'd0, 64'd0, 6'(MAX_STEP));
    send_point(box_lat_min, box_lng_min, 6'(MAX_STEP));
    send_point(box_lat_max, box_lng_max, 6'(MAX_STEP));
    send_point(box_lat_max, box_lng_min, 6'd1);
    send_point(box_lat_max + 64'd1, 64'd0, 6'd5);
    send_point(64'd0, box_lng_min - 64'd1, 6'd5);
    send_point({1'b1, 63'd0}, {1'b0, {63{1'b1}}}, 6'd10);
    send_point({1'b0, {63{1'b1}}}, {1'b1, 63'd0}, 6'd0);
    send_point('1, '1, 6'd7);
  endtask

  // Widest possible box and an empty box on each axis.
  task automatic test_extreme_boxes();
    set_box({1'b1, 63'd0}, {1'b0, {63{1'b1}}}, {1'b1, 63'd0}, {1'b0, {63{1'b1}}});
    send_point({1'b1, 63'd0}, {1'b1, 63'd0}, 6'(MAX_STEP));
    send_point({1'b0, {63{1'b1}}}, {1'b0, {63{1'b1}}}, 6'(MAX_STEP));
    send_point(64'd0, '1, 6'd3);
    send_random_points(30);
    // Empty latitude range wins over an outside point.
    set_box(64'd500, 64'd500, 64'd0, 64'd100);
    send_point(64'd500, 64'd50, 6'd4);
    send_point(64'd9999, 64'd9999, 6'd4);
    // Inverted longitude range.
    set_box(64'd0, 64'd100, 64'd10, -64'sd10);
    send_point(64'd50, 64'd0, 6'd4);
  endtask

  // Random points under a series of random and narrow boxes.
  task automatic test_random_boxes();
    logic [63:0] a, b, c, d;
    for (int phase = 0; phase < 5; phase++) begin
      a = rand64();
      b = rand64();
      c = rand64();
      d = rand64();
      if (phase == 1) begin
        // Narrow spans push the divider through small remainders.
        b = a + 64'($urandom_range(40, 1));
        d = c + 64'($urandom_range(40, 1));
      end
      if (coord_below(b, a)) {a, b} = {b, a};
      if (coord_below(d, c)) {c, d} = {d, c};
      if (phase == 4 && a != b) b = a + 64'd1;
      set_box(a, b, c, d);
      tx_quiet = (phase == 2);
      rx_quiet = (phase == 2);
      send_random_points(200);
      tx_quiet = 0;
      rx_quiet = 0;
    end
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering,
  // so the pipeline fills and input ready drops.
  task automatic test_output_stall();
    tx_quiet = 1;
    hold_request++;
    send_random_points(120);
    tx_quiet = 0;
  endtask

  // Bursts separated by full drains, back on the reset box.
  task automatic test_drain_pauses();
    set_box(-64'sd365291816598, 64'sd365291816598,
            -64'sd773094113280, 64'sd773094113280);
    for (int i = 0; i < 4; i++) begin
      send_random_points(60);
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left   = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 64'd0);
      end else begin
        want = pending_hashes.pop_front();
        if (m_axis_tdata[51:0] !== want.bits)
          report_mismatch("cell_bits", 64'(m_axis_tdata[51:0]), 64'(want.bits));
        if (m_axis_tdata[57:52] !== want.step)
          report_mismatch("cell_step", 64'(m_axis_tdata[57:52]), 64'(want.step));
        if (m_axis_tdata[59:58] !== want.status)
          report_mismatch("status", 64'(m_axis_tdata[59:58]), 64'(want.status));
      end
    end
  end

  // Ends the run if no handshake of any kind completes for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    box_lat_min = 64'd0 - ((64'd85 << 32) + (((64'd5112878 << 32) + 64'd50000000)
                                             / 64'd100000000));
    box_lat_max = 64'd0 - box_lat_min;
    box_lng_min = 64'd0 - (64'd180 << 32);
    box_lng_max = 64'd180 << 32;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_box();
    test_extreme_boxes();
    test_random_boxes();
    test_output_stall();
    test_drain_pauses();

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending_hashes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
